>>> rtl/cuma_pkg.sv
package cuma_pkg;

  // Channel width; ports stay 8 bits wide, only the low COLOR_BITS bits are used.
  localparam int unsigned COLOR_BITS = 8;
  // Numerator and quotient width of the dividers.
  localparam int unsigned NUM_BITS   = 2 * COLOR_BITS;
  localparam int unsigned NUM_CHAN   = 3;
  // prep + divider + merge + prep + divider
  localparam int unsigned PIPE_DEPTH = 2 * NUM_BITS + 3;
  // Pipeline stage that holds the merged alpha.
  localparam int unsigned MERGE_STAGE = NUM_BITS + 1;
  localparam int unsigned ALPHA_LINE  = PIPE_DEPTH - MERGE_STAGE - 1;

  localparam logic [COLOR_BITS-1:0] CH_MAX = {COLOR_BITS{1'b1}};

  typedef logic [COLOR_BITS-1:0] chan_t;

  typedef struct packed {
    chan_t [NUM_CHAN-1:0] fg;
    chan_t                fa;
    chan_t [NUM_CHAN-1:0] bg;
  } side_t;

  typedef struct packed {
    chan_t alpha;
    logic  zero;
  } merge_t;

endpackage

>>> rtl/cuma_div.sv
// Restoring divider, one quotient bit per registered stage.
module cuma_div import cuma_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [NUM_BITS-1:0] num_i,
  input  chan_t               den_i,
  output logic [NUM_BITS-1:0] quo_o
);

  chan_t               rem_q [NUM_BITS];
  logic [NUM_BITS-1:0] num_q [NUM_BITS];
  logic [NUM_BITS-1:0] quo_q [NUM_BITS];
  chan_t               den_q [NUM_BITS];

  chan_t               rem_in [NUM_BITS];
  logic [NUM_BITS-1:0] num_in [NUM_BITS];
  logic [NUM_BITS-1:0] quo_in [NUM_BITS];
  chan_t               den_in [NUM_BITS];
  logic [COLOR_BITS+1:0] trial [NUM_BITS];
  chan_t               rem_d  [NUM_BITS];

  always_comb begin
    for (int s = 0; s < NUM_BITS; s++) begin
      if (s == 0) begin
        rem_in[s] = '0;
        num_in[s] = num_i;
        quo_in[s] = '0;
        den_in[s] = den_i;
      end else begin
        rem_in[s] = rem_q[s-1];
        num_in[s] = num_q[s-1];
        quo_in[s] = quo_q[s-1];
        den_in[s] = den_q[s-1];
      end
      trial[s] = {1'b0, rem_in[s], num_in[s][NUM_BITS-1]} - {2'b00, den_in[s]};
      // partial remainder stays below the divisor, so it fits the channel width
      if (trial[s][COLOR_BITS+1]) begin
        rem_d[s] = {rem_in[s][COLOR_BITS-2:0], num_in[s][NUM_BITS-1]};
      end else begin
        rem_d[s] = trial[s][COLOR_BITS-1:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < NUM_BITS; s++) begin
        rem_q[s] <= rem_d[s];
        num_q[s] <= {num_in[s][NUM_BITS-2:0], 1'b0};
        quo_q[s] <= {quo_in[s][NUM_BITS-2:0], ~trial[s][COLOR_BITS+1]};
        den_q[s] <= den_in[s];
      end
    end
  end

  assign quo_o = quo_q[NUM_BITS-1];

endmodule

>>> rtl/cuma_alpha_lane.sv
// Minimum alpha of one channel: prep stage, then the divider.
module cuma_alpha_lane import cuma_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  chan_t bg_i,
  input  chan_t fg_i,
  output chan_t alpha_o
);

  logic [NUM_BITS-1:0] num_d, num_q;
  chan_t               den_d, den_q;
  chan_t               diff;
  logic [NUM_BITS-1:0] quo;

  always_comb begin
    if (bg_i > fg_i) begin
      diff  = bg_i - fg_i;
      den_d = bg_i;
    end else if (bg_i < fg_i) begin
      diff  = fg_i - bg_i;
      den_d = CH_MAX - bg_i;
    end else begin
      // equal colors: zero numerator, divisor kept nonzero
      diff  = '0;
      den_d = chan_t'(1);
    end
    num_d = NUM_BITS'(diff) * NUM_BITS'(CH_MAX);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      num_q <= num_d;
      den_q <= den_d;
    end
  end

  cuma_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (num_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  // quotient never exceeds full scale
  assign alpha_o = quo[COLOR_BITS-1:0];

endmodule

>>> rtl/cuma_merge.sv
// Largest of the per-channel minimum alphas.
module cuma_merge import cuma_pkg::*; (
  input  logic   clk_i,
  input  logic   en_i,
  input  chan_t  alpha_i [NUM_CHAN],
  output merge_t merge_o
);

  merge_t merge_d, merge_q;
  chan_t  max01;

  always_comb begin
    max01          = (alpha_i[1] > alpha_i[0]) ? alpha_i[1] : alpha_i[0];
    merge_d.alpha  = (alpha_i[2] > max01) ? alpha_i[2] : max01;
    merge_d.zero   = (merge_d.alpha == '0);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      merge_q <= merge_d;
    end
  end

  assign merge_o = merge_q;

endmodule

>>> rtl/cuma_unblend_lane.sv
// Un-blend of one channel: signed numerator, magnitude divide, saturate.
module cuma_unblend_lane import cuma_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  chan_t bg_i,
  input  chan_t fg_i,
  input  chan_t alpha_i,
  output chan_t chan_o,
  output logic  sat_o
);

  logic [NUM_BITS-1:0] fg_term, bg_term;
  logic [NUM_BITS-1:0] mag_d, mag_q;
  logic                neg_d, neg_q;
  chan_t               den_d, den_q;
  logic [NUM_BITS-1:0] quo;
  logic                neg_line_q [NUM_BITS];

  always_comb begin
    fg_term = NUM_BITS'(fg_i) * NUM_BITS'(CH_MAX);
    bg_term = NUM_BITS'(bg_i) * NUM_BITS'(CH_MAX - alpha_i);
    neg_d   = bg_term > fg_term;
    mag_d   = neg_d ? (bg_term - fg_term) : (fg_term - bg_term);
    // alpha of zero is only seen on bypassed items
    den_d   = (alpha_i == '0) ? chan_t'(1) : alpha_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag_q <= mag_d;
      neg_q <= neg_d;
      den_q <= den_d;
      neg_line_q[0] <= neg_q;
      for (int k = 1; k < NUM_BITS; k++) begin
        neg_line_q[k] <= neg_line_q[k-1];
      end
    end
  end

  cuma_div u_div (
    .clk_i (clk_i),
    .en_i  (en_i),
    .num_i (mag_q),
    .den_i (den_q),
    .quo_o (quo)
  );

  // truncation toward zero: a negative numerator smaller than alpha gives 0, not clamped
  always_comb begin
    if (neg_line_q[NUM_BITS-1]) begin
      chan_o = '0;
      sat_o  = (quo != '0);
    end else if (quo > NUM_BITS'(CH_MAX)) begin
      chan_o = CH_MAX;
      sat_o  = 1'b1;
    end else begin
      chan_o = quo[COLOR_BITS-1:0];
      sat_o  = 1'b0;
    end
  end

endmodule

>>> rtl/color_unblend_min_alpha.sv
// Color un-blend to minimum alpha.
// Input channel: a foreground color with alpha and a background color, taken
// on in_valid_i & in_ready_o. Output channel: the un-blended color, its alpha
// and a clamped flag, handed over on out_valid_o & out_ready_i.
// An opaque foreground is reduced to the most transparent color that composites
// to the same pixel over the background; a translucent foreground is passed
// through, and an opaque foreground equal to the background gives all zeros.
// Two pipelined dividers, one quotient bit per stage, lie between acceptance
// and out_valid_o. Throughput: one transaction per cycle unless stalled,
// with three channel lanes side by side.
// Stall: the pipeline advances as a whole. It freezes only while the last
// stage holds a transaction and the output register is full and not taken;
// bubbles keep draining into a waiting output, so input is still accepted.
// Reset: asynchronous, clears all valid bits; the pipeline comes up empty.
module color_unblend_min_alpha import cuma_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] fg_red_i,
  input  logic [7:0] fg_green_i,
  input  logic [7:0] fg_blue_i,
  input  logic [7:0] fg_alpha_i,
  input  logic [7:0] bg_red_i,
  input  logic [7:0] bg_green_i,
  input  logic [7:0] bg_blue_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] res_red_o,
  output logic [7:0] res_green_o,
  output logic [7:0] res_blue_o,
  output logic [7:0] res_alpha_o,
  output logic       clamped_o
);

  logic   en;
  logic   valid_q [PIPE_DEPTH];
  side_t  side_d;
  side_t  side_q [PIPE_DEPTH];
  merge_t alpha_line_q [ALPHA_LINE];
  chan_t  lane_alpha [NUM_CHAN];
  merge_t merged;
  chan_t  chan [NUM_CHAN];
  logic   sat [NUM_CHAN];
  side_t  side_last;
  merge_t alpha_last;

  logic       out_valid_q;
  logic [7:0] res_red_d, res_green_d, res_blue_d, res_alpha_d;
  logic [7:0] res_red_q, res_green_q, res_blue_q, res_alpha_q;
  logic       clamped_d, clamped_q;

  assign en         = !(valid_q[PIPE_DEPTH-1] && out_valid_q && !out_ready_i);
  assign in_ready_o = en;

  always_comb begin
    side_d.fg[0] = chan_t'(fg_red_i);
    side_d.fg[1] = chan_t'(fg_green_i);
    side_d.fg[2] = chan_t'(fg_blue_i);
    side_d.fa    = chan_t'(fg_alpha_i);
    side_d.bg[0] = chan_t'(bg_red_i);
    side_d.bg[1] = chan_t'(bg_green_i);
    side_d.bg[2] = chan_t'(bg_blue_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < PIPE_DEPTH; k++) begin
        valid_q[k] <= 1'b0;
      end
    end else if (en) begin
      valid_q[0] <= in_valid_i;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        valid_q[k] <= valid_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side_d;
      for (int k = 1; k < PIPE_DEPTH; k++) begin
        side_q[k] <= side_q[k-1];
      end
      alpha_line_q[0] <= merged;
      for (int k = 1; k < ALPHA_LINE; k++) begin
        alpha_line_q[k] <= alpha_line_q[k-1];
      end
    end
  end

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_alpha
    cuma_alpha_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .bg_i    (side_d.bg[c]),
      .fg_i    (side_d.fg[c]),
      .alpha_o (lane_alpha[c])
    );
  end

  cuma_merge u_merge (
    .clk_i   (clk_i),
    .en_i    (en),
    .alpha_i (lane_alpha),
    .merge_o (merged)
  );

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_unblend
    cuma_unblend_lane u_lane (
      .clk_i   (clk_i),
      .en_i    (en),
      .bg_i    (side_q[MERGE_STAGE].bg[c]),
      .fg_i    (side_q[MERGE_STAGE].fg[c]),
      .alpha_i (merged.alpha),
      .chan_o  (chan[c]),
      .sat_o   (sat[c])
    );
  end

  assign side_last  = side_q[PIPE_DEPTH-1];
  assign alpha_last = alpha_line_q[ALPHA_LINE-1];

  always_comb begin
    if (side_last.fa != CH_MAX) begin
      // translucent foreground passes through
      res_red_d   = 8'(side_last.fg[0]);
      res_green_d = 8'(side_last.fg[1]);
      res_blue_d  = 8'(side_last.fg[2]);
      res_alpha_d = 8'(side_last.fa);
      clamped_d   = 1'b0;
    end else if (alpha_last.zero) begin
      res_red_d   = '0;
      res_green_d = '0;
      res_blue_d  = '0;
      res_alpha_d = '0;
      clamped_d   = 1'b0;
    end else begin
      res_red_d   = 8'(chan[0]);
      res_green_d = 8'(chan[1]);
      res_blue_d  = 8'(chan[2]);
      res_alpha_d = 8'(alpha_last.alpha);
      clamped_d   = sat[0] | sat[1] | sat[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_valid_q || out_ready_i) begin
      out_valid_q <= valid_q[PIPE_DEPTH-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || out_ready_i) begin
      res_red_q   <= res_red_d;
      res_green_q <= res_green_d;
      res_blue_q  <= res_blue_d;
      res_alpha_q <= res_alpha_d;
      clamped_q   <= clamped_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_red_o   = res_red_q;
  assign res_green_o = res_green_q;
  assign res_blue_o  = res_blue_q;
  assign res_alpha_o = res_alpha_q;
  assign clamped_o   = clamped_q;

endmodule

>>> rtl/cuma_checker.sv
module cuma_checker import cuma_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic [7:0] fg_red_i,
  input logic [7:0] fg_green_i,
  input logic [7:0] fg_blue_i,
  input logic [7:0] fg_alpha_i,
  input logic [7:0] bg_red_i,
  input logic [7:0] bg_green_i,
  input logic [7:0] bg_blue_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [7:0] res_red_o,
  input logic [7:0] res_green_o,
  input logic [7:0] res_blue_o,
  input logic [7:0] res_alpha_o,
  input logic       clamped_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(res_red_o) &&
      $stable(res_green_o) && $stable(res_blue_o) && $stable(res_alpha_o) &&
      $stable(clamped_o))
    else $error("result changed while stalled");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output backpressure");

  // saturation needs a partial alpha
  a_clamp_alpha: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && clamped_o |-> res_alpha_o != 8'd0 && res_alpha_o != 8'(CH_MAX))
    else $error("clamped result with zero or full alpha");

  // nothing comes out of an empty pipeline
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !out_valid_o)
    else $error("result valid right after reset");

endmodule

bind color_unblend_min_alpha cuma_checker u_cuma_checker (.*);
